@@ design/phvf_pkg.sv @@
// ----------------------------------------------------------------------------
// phvf_pkg: shared types and constants for the polar histogram valley finder
// Field widths, register indexes, reset values and the front-to-back word.
// ----------------------------------------------------------------------------
package phvf_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_SECTORS    = 512;
    localparam int DEF_MAX_HALF_WIDTH = 16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Field widths fixed by the interface
    localparam int CERT_W     = 8;
    localparam int HALF_CFG_W = 5;
    localparam int THR_W      = 8;
    localparam int MINW_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SI_W       = 9;
    localparam int WGT_W      = 8;
    localparam int VB_W       = 10;
    localparam int VW_W       = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH  = 2'd2;

    // Configuration reset values
    localparam logic [HALF_CFG_W-1:0] RST_HALF_WIDTH = 5'd5;
    localparam logic [THR_W-1:0]      RST_THRESHOLD  = 8'd5;
    localparam logic [MINW_W-1:0]     RST_MIN_WIDTH  = 9'd17;

    // Saturation limit of the smoothed weight
    localparam logic [WGT_W-1:0] WGT_MAX = 8'hFF;

    // Classified input word handed from front to back
    typedef struct packed {
        logic [CERT_W-1:0] certainty;
        logic              last;
    } phvf_cmd_t;

    // One result word
    typedef struct packed {
        logic [SI_W-1:0]  sector_index;
        logic [WGT_W-1:0] smoothed_weight;
        logic             is_safe;
        logic             valley_found;
        logic [VB_W-1:0]  valley_begin;
        logic [VW_W-1:0]  valley_width;
        logic             last_of_scan;
    } phvf_result_t;

endpackage

@@ design/phvf_front.sv @@
// ----------------------------------------------------------------------------
// phvf_front: input acceptor and scan classifier
// Counts sectors of the scan and marks the word that ends it.
// ----------------------------------------------------------------------------
module phvf_front
    import phvf_pkg::*;
#(
    parameter int MAX_SECTORS = DEF_MAX_SECTORS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CERT_W-1:0] certainty,
    input  logic              end_of_scan,
    output logic              q_push,
    output phvf_cmd_t         q_cmd,
    input  logic              q_full
);

    localparam int SEC_W = $clog2(MAX_SECTORS + 1);

    logic [SEC_W-1:0] count_reg;
    logic [SEC_W-1:0] count_next;
    logic [SEC_W-1:0] count_inc;
    logic             last;

    assign in_ready  = !q_full;
    assign q_push    = in_valid && in_ready;
    assign count_inc = count_reg + SEC_W'(1);

    // Force scan end once the sector limit is reached
    assign last = end_of_scan || (count_inc >= SEC_W'(MAX_SECTORS));

    assign q_cmd.certainty = certainty;
    assign q_cmd.last      = last;

    always_comb
    begin
        count_next = count_reg;
        if (q_push)
        begin
            count_next = last ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ design/phvf_queue.sv @@
// ----------------------------------------------------------------------------
// phvf_queue: short word queue between front and back
// Lets the front keep accepting while the back works on a word.
// ----------------------------------------------------------------------------
module phvf_queue
    import phvf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  phvf_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output phvf_cmd_t pop_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    phvf_cmd_t       slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic            do_pop;

    assign full    = (cnt_reg == CW'(QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || do_pop))
        else $error("queue written while full");
`endif

endmodule

@@ design/phvf_back.sv @@
// ----------------------------------------------------------------------------
// phvf_back: window smoother, divider and valley tracker
// Holds the certainty window, runs one multiply-accumulate per cycle over the
// triangular window, divides by 2L+1 one bit per cycle, then grades valleys.
// ----------------------------------------------------------------------------
module phvf_back
    import phvf_pkg::*;
#(
    parameter int MAX_SECTORS    = DEF_MAX_SECTORS,
    parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  phvf_cmd_t             q_cmd,
    output logic                  q_pop,
    input  logic [HALF_CFG_W-1:0] cfg_half,
    input  logic [THR_W-1:0]      cfg_threshold,
    input  logic [MINW_W-1:0]     cfg_min_width,
    output logic                  out_valid,
    input  logic                  out_ready,
    output phvf_result_t          out_res
);

    localparam int SEC_W = $clog2(MAX_SECTORS + 1);
    localparam int HW    = $clog2(MAX_HALF_WIDTH + 1);
    localparam int WIN_D = 2 * MAX_HALF_WIDTH - 1;
    localparam int AG_W  = (WIN_D > 1) ? $clog2(WIN_D) : 1;
    localparam int KW    = AG_W;
    localparam int NW    = (SEC_W > HW) ? SEC_W : HW;
    localparam int J_W   = NW + 2;
    localparam int CLW   = (HW > HALF_CFG_W) ? HW : HALF_CFG_W;
    localparam int SUM_W = $clog2(256 * MAX_HALF_WIDTH * MAX_HALF_WIDTH);
    localparam int D_W   = HW + 1;
    localparam int DC_W  = $clog2(SUM_W + 1);
    localparam int AW    = ((SEC_W > VB_W) ? SEC_W : VB_W) + 2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_MAC    = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_RESULT = 5'b10000
    } phvf_state_t;

    phvf_state_t         state_reg, state_next;
    logic [CERT_W-1:0]   win_reg [WIN_D];
    logic [SEC_W-1:0]    n_reg, n_next;
    logic [HW-1:0]       half_reg, half_next;
    logic                last_reg, last_next;
    logic [SEC_W-1:0]    i_reg, i_next;
    logic [SEC_W-1:0]    i_end_reg, i_end_next;
    logic signed [J_W-1:0] j_reg, j_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [HW-1:0]       wt_reg, wt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [D_W-1:0]      rem_reg, rem_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [DC_W-1:0]     dcnt_reg, dcnt_next;
    logic                flag_reg, flag_next;
    logic [VB_W-1:0]     vstart_reg, vstart_next;
    logic                out_valid_reg, out_valid_next;
    phvf_result_t        out_res_reg, out_res_next;

    logic                load;
    logic [CLW-1:0]      cfg_half_ext;
    logic [HW-1:0]       half_clamped;
    logic [HW-1:0]       l_eff;
    logic [SEC_W-1:0]    n_inc;
    logic                enough;
    logic [SEC_W-1:0]    i_first;
    logic signed [J_W-1:0] age_full;
    logic                j_in_scan;
    logic [CERT_W-1:0]   tap;
    logic [CERT_W+HW-1:0] prod;
    logic [SUM_W-1:0]    sum_acc;
    logic [KW-1:0]       k_last;
    logic [D_W-1:0]      divisor;
    logic [D_W:0]        trial;
    logic [WGT_W-1:0]    weight;
    logic                safe;
    logic signed [AW-1:0] angle;
    logic                found;
    logic [VB_W-1:0]     start_cand;
    phvf_result_t        res;

    // Half width in use: latch at first sector, clamp into 1..MAX_HALF_WIDTH
    assign cfg_half_ext = CLW'(cfg_half);
    always_comb
    begin
        if (cfg_half_ext == '0)
        begin
            half_clamped = HW'(1);
        end
        else if (cfg_half_ext > CLW'(MAX_HALF_WIDTH))
        begin
            half_clamped = HW'(MAX_HALF_WIDTH);
        end
        else
        begin
            half_clamped = cfg_half_ext[HW-1:0];
        end
    end

    assign l_eff   = (n_reg == '0) ? half_clamped : half_reg;
    assign n_inc   = n_reg + SEC_W'(1);
    assign enough  = (NW'(n_inc) >= NW'(l_eff));
    assign i_first = SEC_W'(NW'(n_inc) - NW'(l_eff));

    // Window tap for sector j; sectors outside the scan read as zero
    assign age_full  = $signed(J_W'(n_reg)) - $signed(J_W'(1)) - j_reg;
    assign j_in_scan = !j_reg[J_W-1] && (j_reg < $signed(J_W'(n_reg)));
    assign tap       = j_in_scan ? win_reg[age_full[AG_W-1:0]] : '0;
    assign prod      = (CERT_W+HW)'(tap) * (CERT_W+HW)'(wt_reg);
    assign sum_acc   = sum_reg + SUM_W'(prod);
    assign k_last    = KW'({half_reg, 1'b0} - D_W'(2));

    // Restoring division step by 2L+1
    assign divisor = {half_reg, 1'b1};
    assign trial   = {rem_reg, quo_reg[SUM_W-1]};

    // Grade the finished sector
    assign weight     = (quo_reg > SUM_W'(WGT_MAX)) ? WGT_MAX : quo_reg[WGT_W-1:0];
    assign safe       = (weight < cfg_threshold);
    assign angle      = $signed(AW'(i_reg)) - $signed(AW'(1)) - $signed(AW'(vstart_reg));
    assign found      = flag_reg && !safe && (angle >= $signed(AW'(cfg_min_width)));
    assign start_cand = VB_W'({1'b0, i_reg} + (SEC_W+1)'(1));

    always_comb
    begin
        res.sector_index    = SI_W'(i_reg);
        res.smoothed_weight = weight;
        res.is_safe         = safe;
        res.valley_found    = found;
        res.valley_begin    = found ? vstart_reg : '0;
        res.valley_width    = found ? angle[VW_W-1:0] : '0;
        res.last_of_scan    = last_reg && (i_reg == i_end_reg);
    end

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        half_next    = half_reg;
        last_next    = last_reg;
        i_next       = i_reg;
        i_end_next   = i_end_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        wt_next      = wt_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        flag_next    = flag_reg;
        vstart_next  = vstart_reg;
        out_res_next = out_res_reg;
        q_pop        = 1'b0;
        load         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    n_next    = n_inc;
                    half_next = l_eff;
                    last_next = q_cmd.last;
                    if (q_cmd.last)
                    begin
                        // Flush the remaining sectors of the scan
                        i_next     = enough ? i_first : '0;
                        i_end_next = n_inc - SEC_W'(1);
                        state_next = ST_START;
                    end
                    else if (enough)
                    begin
                        i_next     = i_first;
                        i_end_next = i_first;
                        state_next = ST_START;
                    end
                end
            end

            ST_START:
            begin
                j_next     = $signed(J_W'(i_reg)) - $signed(J_W'(half_reg)) + $signed(J_W'(1));
                k_next     = '0;
                wt_next    = HW'(1);
                sum_next   = '0;
                state_next = ST_MAC;
            end

            ST_MAC:
            begin
                sum_next = sum_acc;
                j_next   = j_reg + $signed(J_W'(1));
                k_next   = k_reg + KW'(1);
                if ((D_W'(k_reg) + D_W'(1)) < D_W'(half_reg))
                begin
                    wt_next = wt_reg + HW'(1);
                end
                else
                begin
                    wt_next = wt_reg - HW'(1);
                end
                if (k_reg == k_last)
                begin
                    // Add L for round-to-nearest, then divide
                    quo_next   = sum_acc + SUM_W'(half_reg);
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (trial >= (D_W+1)'(divisor))
                begin
                    rem_next = D_W'(trial - (D_W+1)'(divisor));
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[D_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DC_W'(1);
                if (dcnt_reg == DC_W'(SUM_W - 1))
                begin
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load         = 1'b1;
                    out_res_next = res;
                    if (!flag_reg && safe)
                    begin
                        flag_next   = 1'b1;
                        vstart_next = start_cand;
                    end
                    else if (flag_reg && !safe)
                    begin
                        flag_next = 1'b0;
                    end
                    if (i_reg == i_end_reg)
                    begin
                        if (last_reg)
                        begin
                            // Drop any valley still open at scan end
                            n_next    = '0;
                            flag_next = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + SEC_W'(1);
                        state_next = ST_START;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        half_reg    <= half_next;
        last_reg    <= last_next;
        i_reg       <= i_next;
        i_end_reg   <= i_end_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        wt_reg      <= wt_next;
        sum_reg     <= sum_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dcnt_reg    <= dcnt_next;
        vstart_reg  <= vstart_next;
        out_res_reg <= out_res_next;
    end

    // Certainty shift line, newest at tap zero
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            win_reg[0] <= q_cmd.certainty;
            for (int t = 1; t < WIN_D; t++)
            begin
                win_reg[t] <= win_reg[t-1];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

`ifndef ASSERT_OFF
    a_mac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (k_reg <= k_last))
        else $error("window step past its end");

    a_found_unsafe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.valley_found) |-> !out_res_reg.is_safe)
        else $error("valley reported on a safe sector");

    a_scan_close: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_reg && (i_reg == i_end_reg)) |=> ((n_reg == '0) && !flag_reg))
        else $error("scan state not cleared at scan end");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= SEC_W'(MAX_SECTORS))
        else $error("sector count beyond limit");
`endif

endmodule

@@ design/polar_histogram_valley_finder.sv @@
// ----------------------------------------------------------------------------
// polar_histogram_valley_finder: polar histogram smoother and valley finder
// Flow: an idle back end pops an accepted word in the cycle after it is accepted;
//   each result passes ST_START, one window step per cycle over 2L-1 sectors in
//   ST_MAC, one quotient bit per cycle in ST_DIV (SUM_W = 16 at MAX_HALF_WIDTH =
//   16), ST_RESULT. A scan's final word yields up to L results, one after another.
// Reset: rst_n clears all control state; registers return to L=5, thr=5, min=17.
// ----------------------------------------------------------------------------
module polar_histogram_valley_finder
    import phvf_pkg::*;
#(
    parameter int MAX_SECTORS    = DEF_MAX_SECTORS,
    parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input channel: one certainty word per sector
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CERT_W-1:0]     certainty,
    input  logic                  end_of_scan,

    // Result channel: one word per smoothed sector
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SI_W-1:0]       sector_index,
    output logic [WGT_W-1:0]      smoothed_weight,
    output logic                  is_safe,
    output logic                  valley_found,
    output logic [VB_W-1:0]       valley_begin,
    output logic [VW_W-1:0]       valley_width,
    output logic                  last_of_scan,

    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [HALF_CFG_W-1:0] half_width_reg;
    logic [THR_W-1:0]      threshold_reg;
    logic [MINW_W-1:0]     min_width_reg;

    logic         q_push;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    phvf_cmd_t    push_cmd;
    phvf_cmd_t    pop_cmd;
    phvf_result_t res;

    // Configuration registers take writes at any time; the half width is
    // latched by the back end at each scan's first sector, the threshold and
    // minimum valley width act on the next graded sector.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= RST_HALF_WIDTH;
            threshold_reg  <= RST_THRESHOLD;
            min_width_reg  <= RST_MIN_WIDTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HALF_WIDTH: half_width_reg <= cfg_data[HALF_CFG_W-1:0];
                CFG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                CFG_MIN_WIDTH:  min_width_reg  <= cfg_data[MINW_W-1:0];
                default:        ;
            endcase
        end
    end

    // Front end: accept words, count sectors, flag the one that ends the scan
    phvf_front #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .certainty   (certainty),
        .end_of_scan (end_of_scan),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .q_full      (q_full)
    );

    // Hold classified words while the back end is busy with earlier ones
    phvf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    // Back end: window, multiply-accumulate, divider, valley grading and the
    // output register that parts it from the result channel
    phvf_back #(
        .MAX_SECTORS    (MAX_SECTORS),
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .cfg_half      (half_width_reg),
        .cfg_threshold (threshold_reg),
        .cfg_min_width (min_width_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_res       (res)
    );

    // Unpack the result word onto its field ports
    assign sector_index    = res.sector_index;
    assign smoothed_weight = res.smoothed_weight;
    assign is_safe         = res.is_safe;
    assign valley_found    = res.valley_found;
    assign valley_begin    = res.valley_begin;
    assign valley_width    = res.valley_width;
    assign last_of_scan    = res.last_of_scan;

endmodule
